FILE: rtl/ffha_pkg.sv
// shared types and constants of the first-fit heap allocator
package ffha_pkg;

    localparam int MAX_CHUNKS   = 64;
    localparam int IDX_W        = $clog2(MAX_CHUNKS);
    localparam int CNT_W        = $clog2(MAX_CHUNKS + 1);
    localparam int HEADER_BYTES = 24;
    localparam int OFFSET_BITS  = 24;
    localparam int SIZE_W       = OFFSET_BITS + 1;
    localparam int ALIGN_MASK   = 15;
    localparam int MIN_SPLIT    = 16;

    // result status codes
    typedef enum logic [2:0] {
        STAT_DONE      = 3'd0,
        STAT_NULL      = 3'd1,
        STAT_EXHAUSTED = 3'd2,
        STAT_FULL      = 3'd3,
        STAT_NOT_FOUND = 3'd4
    } status_t;

    // one chunk table entry
    typedef struct packed {
        logic                   is_free;
        logic [SIZE_W-1:0]      bytes;
        logic [OFFSET_BITS-1:0] start;
    } entry_t;

    // table write port
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } tbl_wr_t;

endpackage

FILE: rtl/ffha_table.sv
// chunk table memory with one write port and one registered read port
module ffha_table (
    input  logic                        aclk,
    input  ffha_pkg::tbl_wr_t           wr,
    input  logic [ffha_pkg::IDX_W-1:0]  rd_addr,
    output ffha_pkg::entry_t            rd_data
);
    import ffha_pkg::*;

    entry_t mem [MAX_CHUNKS];
    entry_t rd_data_reg;

    // write and registered read
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/first_fit_heap_allocator_top.sv
// top level of the first-fit heap allocator
// First-fit heap allocator over an address-ordered chunk table held in one
// synchronous memory. One request is worked at a time. An allocation of size
// zero or a null free goes straight to S_RESP, which loads its result into the
// output register once the previous result has been taken. The first-fit
// search reads one entry per cycle and stops at the matching entry. A split
// that inserts an entry, or a merge that removes one, then moves the entries
// above it one per cycle. The next request can be taken in the same cycle that
// the result is in the output register. heap_limit is to be written through
// cfg_wr_en / cfg_wr_data only while idle; the block itself does not enforce it.
module first_fit_heap_allocator_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [24:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: req_size [23:0], payload_offset [47:24]
    input  logic [47:0] s_tdata,
    // tuser: command [0]
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: result_offset [23:0]
    output logic [23:0] m_tdata,
    // tuser: status [2:0]
    output logic [2:0]  m_tuser
);
    import ffha_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_SEARCH   = 8'b0000_0010,
        S_NEXT_RD  = 8'b0000_0100,
        S_NEXT_CHK = 8'b0000_1000,
        S_SHIFT    = 8'b0001_0000,
        S_WR_A     = 8'b0010_0000,
        S_WR_B     = 8'b0100_0000,
        S_RESP     = 8'b1000_0000
    } state_t;

    localparam logic [SIZE_W-1:0] ADDR_CAP = SIZE_W'(1) << OFFSET_BITS;
    localparam logic [SIZE_W:0]   HDR_W1   = (SIZE_W+1)'(HEADER_BYTES);
    localparam logic [SIZE_W:0]   SPLIT_W1 = (SIZE_W+1)'(HEADER_BYTES + MIN_SPLIT);

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [SIZE_W-1:0]      top_reg, top_next;
    logic [SIZE_W-1:0]      limit_reg;
    logic                   op_free_reg, op_free_next;
    logic [SIZE_W-1:0]      need_reg, need_next;
    logic [OFFSET_BITS-1:0] off_reg, off_next;
    logic [CNT_W-1:0]       iss_reg, iss_next;
    logic                   chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0]       chk_idx_reg, chk_idx_next;
    logic [IDX_W-1:0]       hit_idx_reg, hit_idx_next;
    logic [OFFSET_BITS-1:0] hit_start_reg, hit_start_next;
    logic [SIZE_W-1:0]      hit_bytes_reg, hit_bytes_next;
    logic                   split_reg, split_next;
    logic [CNT_W-1:0]       sh_cnt_reg, sh_cnt_next;
    logic [CNT_W-1:0]       sh_src_reg, sh_src_next;
    logic [CNT_W-1:0]       sh_dst_reg, sh_dst_next;
    logic                   sh_up_reg, sh_up_next;
    logic                   mv_pend_reg, mv_pend_next;
    logic [IDX_W-1:0]       mv_dst_reg, mv_dst_next;
    status_t                stat_reg, stat_next;
    logic [OFFSET_BITS-1:0] res_reg, res_next;
    logic                   m_valid_reg, m_valid_next;
    status_t                m_stat_reg, m_stat_next;
    logic [OFFSET_BITS-1:0] m_off_reg, m_off_next;

    tbl_wr_t                wr;
    logic [IDX_W-1:0]       rd_addr;
    entry_t                 rd_data;

    logic [SIZE_W-1:0]      eff_limit;
    logic [SIZE_W:0]        grow_end;
    logic [SIZE_W:0]        hit_pay;
    logic                   alloc_hit;
    logic                   free_hit;
    logic [SIZE_W-1:0]      req_need;

    ffha_table u_table (
        .aclk    (aclk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // datapath helpers
    assign eff_limit = (limit_reg > ADDR_CAP) ? ADDR_CAP : limit_reg;
    assign grow_end  = {1'b0, top_reg} + HDR_W1 + {1'b0, need_reg};
    assign hit_pay   = {2'b00, rd_data.start} + HDR_W1;
    assign alloc_hit = chk_valid_reg && rd_data.is_free && (rd_data.bytes >= need_reg);
    assign free_hit  = chk_valid_reg && (hit_pay == {2'b00, off_reg});
    assign req_need  = ({1'b0, s_tdata[23:0]} + SIZE_W'(ALIGN_MASK))
                       & ~SIZE_W'(ALIGN_MASK);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_off_reg;
    assign m_tuser  = m_stat_reg;

    // request sequencer
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        top_next       = top_reg;
        op_free_next   = op_free_reg;
        need_next      = need_reg;
        off_next       = off_reg;
        iss_next       = iss_reg;
        chk_valid_next = 1'b0;
        chk_idx_next   = chk_idx_reg;
        hit_idx_next   = hit_idx_reg;
        hit_start_next = hit_start_reg;
        hit_bytes_next = hit_bytes_reg;
        split_next     = split_reg;
        sh_cnt_next    = sh_cnt_reg;
        sh_src_next    = sh_src_reg;
        sh_dst_next    = sh_dst_reg;
        sh_up_next     = sh_up_reg;
        mv_pend_next   = 1'b0;
        mv_dst_next    = mv_dst_reg;
        stat_next      = stat_reg;
        res_next       = res_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_stat_next    = m_stat_reg;
        m_off_next     = m_off_reg;
        wr             = '0;
        rd_addr        = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_free_next = s_tuser;
                    need_next    = req_need;
                    off_next     = s_tdata[47:24];
                    iss_next     = '0;
                    res_next     = '0;
                    split_next   = 1'b0;
                    if ((s_tuser && s_tdata[47:24] == '0) ||
                        (!s_tuser && s_tdata[23:0] == '0)) begin
                        stat_next  = STAT_NULL;
                        state_next = S_RESP;
                    end else begin
                        state_next = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                // one read issued per cycle, its registered data checked in the next cycle
                if (iss_reg < count_reg) begin
                    rd_addr        = iss_reg[IDX_W-1:0];
                    iss_next       = iss_reg + CNT_W'(1);
                    chk_valid_next = 1'b1;
                    chk_idx_next   = iss_reg[IDX_W-1:0];
                end
                hit_idx_next   = chk_idx_reg;
                hit_start_next = rd_data.start;
                hit_bytes_next = rd_data.bytes;
                if (!op_free_reg && alloc_hit) begin
                    chk_valid_next = 1'b0;
                    res_next       = OFFSET_BITS'(hit_pay);
                    stat_next      = STAT_DONE;
                    if (({1'b0, rd_data.bytes} >= {1'b0, need_reg} + SPLIT_W1) &&
                        (count_reg < CNT_W'(MAX_CHUNKS))) begin
                        split_next  = 1'b1;
                        sh_up_next  = 1'b1;
                        sh_cnt_next = count_reg - CNT_W'(1) - {1'b0, chk_idx_reg};
                        sh_src_next = count_reg - CNT_W'(1);
                        sh_dst_next = count_reg;
                        count_next  = count_reg + CNT_W'(1);
                        state_next  = S_SHIFT;
                    end else begin
                        state_next = S_WR_A;
                    end
                end else if (op_free_reg && free_hit) begin
                    chk_valid_next = 1'b0;
                    stat_next      = STAT_DONE;
                    if ({1'b0, chk_idx_reg} + CNT_W'(1) < count_reg) begin
                        state_next = S_NEXT_RD;
                    end else begin
                        state_next = S_WR_A;
                    end
                end else if (!chk_valid_reg && iss_reg == count_reg) begin
                    chk_valid_next = 1'b0;
                    state_next     = S_RESP;
                    if (op_free_reg) begin
                        stat_next = STAT_NOT_FOUND;
                    end else if (count_reg >= CNT_W'(MAX_CHUNKS)) begin
                        stat_next = STAT_FULL;
                    end else if (grow_end > {1'b0, eff_limit}) begin
                        stat_next = STAT_EXHAUSTED;
                    end else begin
                        // append a new chunk at the heap top
                        wr.en           = 1'b1;
                        wr.addr         = count_reg[IDX_W-1:0];
                        wr.data.start   = top_reg[OFFSET_BITS-1:0];
                        wr.data.bytes   = need_reg;
                        wr.data.is_free = 1'b0;
                        stat_next       = STAT_DONE;
                        res_next        = OFFSET_BITS'({1'b0, top_reg} + HDR_W1);
                        top_next        = SIZE_W'(grow_end);
                        count_next      = count_reg + CNT_W'(1);
                    end
                end
            end
            S_NEXT_RD: begin
                rd_addr    = hit_idx_reg + IDX_W'(1);
                state_next = S_NEXT_CHK;
            end
            S_NEXT_CHK: begin
                // merge with a free next chunk
                if (rd_data.is_free) begin
                    hit_bytes_next = SIZE_W'({1'b0, hit_bytes_reg} + HDR_W1
                                             + {1'b0, rd_data.bytes});
                    sh_up_next  = 1'b0;
                    sh_cnt_next = count_reg - CNT_W'(2) - {1'b0, hit_idx_reg};
                    sh_src_next = {1'b0, hit_idx_reg} + CNT_W'(2);
                    sh_dst_next = {1'b0, hit_idx_reg} + CNT_W'(1);
                    count_next  = count_reg - CNT_W'(1);
                    state_next  = S_SHIFT;
                end else begin
                    state_next = S_WR_A;
                end
            end
            S_SHIFT: begin
                // move entries one place, each read and then written in the next cycle
                if (sh_cnt_reg != '0) begin
                    rd_addr      = sh_src_reg[IDX_W-1:0];
                    mv_pend_next = 1'b1;
                    mv_dst_next  = sh_dst_reg[IDX_W-1:0];
                    sh_cnt_next  = sh_cnt_reg - CNT_W'(1);
                    if (sh_up_reg) begin
                        sh_src_next = sh_src_reg - CNT_W'(1);
                        sh_dst_next = sh_dst_reg - CNT_W'(1);
                    end else begin
                        sh_src_next = sh_src_reg + CNT_W'(1);
                        sh_dst_next = sh_dst_reg + CNT_W'(1);
                    end
                end
                if (mv_pend_reg) begin
                    wr.en   = 1'b1;
                    wr.addr = mv_dst_reg;
                    wr.data = rd_data;
                end
                if (sh_cnt_reg == '0 && !mv_pend_reg) begin
                    state_next = S_WR_A;
                end
            end
            S_WR_A: begin
                wr.en           = 1'b1;
                wr.addr         = hit_idx_reg;
                wr.data.start   = hit_start_reg;
                wr.data.bytes   = split_reg ? need_reg : hit_bytes_reg;
                wr.data.is_free = op_free_reg;
                state_next      = split_reg ? S_WR_B : S_RESP;
            end
            S_WR_B: begin
                // free remainder of a split chunk
                wr.en           = 1'b1;
                wr.addr         = hit_idx_reg + IDX_W'(1);
                wr.data.start   = OFFSET_BITS'({2'b00, hit_start_reg} + HDR_W1
                                               + {1'b0, need_reg});
                wr.data.bytes   = SIZE_W'({1'b0, hit_bytes_reg} - {1'b0, need_reg}
                                          - HDR_W1);
                wr.data.is_free = 1'b1;
                state_next      = S_RESP;
            end
            S_RESP: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_stat_next  = stat_reg;
                    m_off_next   = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            top_reg       <= '0;
            limit_reg     <= SIZE_W'(1048576);
            chk_valid_reg <= 1'b0;
            mv_pend_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            top_reg       <= top_next;
            chk_valid_reg <= chk_valid_next;
            mv_pend_reg   <= mv_pend_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        op_free_reg   <= op_free_next;
        need_reg      <= need_next;
        off_reg       <= off_next;
        iss_reg       <= iss_next;
        chk_idx_reg   <= chk_idx_next;
        hit_idx_reg   <= hit_idx_next;
        hit_start_reg <= hit_start_next;
        hit_bytes_reg <= hit_bytes_next;
        split_reg     <= split_next;
        sh_cnt_reg    <= sh_cnt_next;
        sh_src_reg    <= sh_src_next;
        sh_dst_reg    <= sh_dst_next;
        sh_up_reg     <= sh_up_next;
        mv_dst_reg    <= mv_dst_next;
        stat_reg      <= stat_next;
        res_reg       <= res_next;
        m_stat_reg    <= m_stat_next;
        m_off_reg     <= m_off_next;
    end

`ifndef ASSERT_OFF
    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_CHUNKS))
        else $error("chunk count above table size");

    a_top_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        top_reg <= ADDR_CAP)
        else $error("heap top beyond offset range");

    a_shift_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SHIFT && mv_pend_reg && sh_cnt_reg != '0)
        |-> (mv_dst_reg != sh_src_reg[IDX_W-1:0]))
        else $error("entry move reads and writes the same entry");

    a_accept_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == S_SEARCH || state_reg == S_RESP))
        else $error("accepted request not started");
`endif

endmodule
